>>> rtl/srm_pkg.sv
// Shared types, constants and a conversion helper for the servo ramp multiplexer.
package srm_pkg;

  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_TARGETS = 3'd1,
    MODE_WR_MIN  = 3'd2,
    MODE_WR_MAX  = 3'd3,
    MODE_WR_TIME = 3'd4,
    MODE_RD_MIN  = 3'd5,
    MODE_RD_MAX  = 3'd6,
    MODE_RD_TIME = 3'd7
  } mode_e;

  localparam logic [9:0]  PERMILLE_MAX = 10'd1000;
  localparam logic [9:0]  TIME_MIN     = 10'd20;
  localparam logic [9:0]  TIME_MAX     = 10'd1000;
  localparam logic [9:0]  WIDTH_BASE   = 10'd500;
  localparam logic [5:0]  STEP_MASK    = 6'h3F;
  localparam int unsigned DIVIDEND_W   = 11;

  // One channel's entry in the settings/state memory
  typedef struct packed {
    logic [9:0] min_p;
    logic [9:0] max_p;
    logic [9:0] move_time;
    logic [9:0] min_w;
    logic [9:0] max_w;
    logic [9:0] cur_w;
    logic [5:0] step;
    logic [3:0] hold;
  } srm_entry_t;

  localparam srm_entry_t RESET_ENTRY = '{
    min_p:     10'd400,
    max_p:     10'd600,
    move_time: 10'd100,
    min_w:     10'd700,
    max_w:     10'd800,
    cur_w:     10'd700,
    step:      6'd2,
    hold:      4'd0
  };

  typedef struct packed {
    srm_entry_t ent;
    logic       start_f;
    logic       target_f;
    logic       dir_f;
    logic       slot_free;
  } srm_tick_in_t;

  typedef struct packed {
    srm_entry_t ent;
    logic       started;
    logic       dir;
    logic       pulse;
    logic [9:0] width;
    logic       reach_set;
    logic       reach_clr;
    logic       finished;
  } srm_tick_out_t;

  function automatic logic [9:0] permille_to_width(logic [9:0] p);
    logic [9:0] pc;
    pc = (p > PERMILLE_MAX) ? PERMILLE_MAX : p;
    return (pc >> 1) + WIDTH_BASE;
  endfunction

endpackage

>>> rtl/srm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module srm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/srm_div.sv
// Restoring divider, one quotient bit per cycle.
module srm_div #(
  parameter int unsigned DW = 11,
  parameter int unsigned VW = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [VW:0]   rem_q;
  logic [DW-1:0] quo_q;
  logic [VW-1:0] dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  logic [VW:0]   rem_sh;
  logic [VW+1:0] trial;
  logic          borrow;

  assign rem_sh = {rem_q[VW-1:0], quo_q[DW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign borrow = trial[VW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CW'(DW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= borrow ? rem_sh : trial[VW:0];
      quo_q <= {quo_q[DW-2:0], ~borrow};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> rtl/srm_ramp.sv
// Ramp step for one channel tick: move start, width step, end snap and hold count.
module srm_ramp #(
  parameter int unsigned HOLD_PULSES = 15
) (
  input  srm_pkg::srm_tick_in_t  tick_i,
  output srm_pkg::srm_tick_out_t tick_o
);

  srm_pkg::srm_entry_t ent;
  logic       start;
  logic [3:0] hold0;
  logic [3:0] hold1;
  logic       dir;
  logic       run;
  logic [10:0] sum;
  logic       hit_up;
  logic       hit_dn;
  logic [9:0] diff;
  logic [9:0] new_w;
  logic       hit;

  always_comb begin
    ent    = tick_i.ent;
    start  = (ent.hold == 4'd0) && tick_i.start_f && tick_i.slot_free;
    hold0  = start ? 4'(HOLD_PULSES) : ent.hold;
    dir    = start ? tick_i.target_f : tick_i.dir_f;
    run    = (hold0 != 4'd0);
    sum    = {1'b0, ent.cur_w} + {5'd0, ent.step};
    hit_up = (sum >= {1'b0, ent.max_w});
    // cur - step <= min, kept unsigned
    hit_dn = ({1'b0, ent.cur_w} <= ({1'b0, ent.min_w} + {5'd0, ent.step}));
    diff   = ent.cur_w - {4'd0, ent.step};
    if (!run) begin
      new_w = ent.cur_w;
      hit   = 1'b0;
    end else if (dir) begin
      new_w = hit_up ? ent.max_w : sum[9:0];
      hit   = hit_up;
    end else begin
      new_w = hit_dn ? ent.min_w : diff;
      hit   = hit_dn;
    end
    hold1 = hit ? (hold0 - 4'd1) : hold0;

    tick_o           = '0;
    tick_o.ent       = ent;
    tick_o.ent.cur_w = new_w;
    tick_o.ent.hold  = hold1;
    tick_o.started   = start;
    tick_o.dir       = dir;
    tick_o.pulse     = run;
    tick_o.width     = run ? new_w : 10'd0;
    tick_o.reach_set = hit && dir;
    tick_o.reach_clr = hit && !dir;
    tick_o.finished  = run && (hold1 == 4'd0);
  end

endmodule

>>> rtl/servo_ramp_multiplexer.sv
// Top level: round-robin servo ramp controller with per-channel settings in one RAM.
//
//  port group   | dir | contents (low bit first)
//  s_axis_*     | in  | tuser: mode[2:0]; tdata: channel[2:0], data[18:3], select_mask[26:19]
//  m_axis_*     | out | tdata: pulse_valid, pulse_channel, pulse_width, reached_bits,
//               |     |        pending_bits, read_value (40 bits)
//  cfg_*        | in  | cfg_we_i / cfg_wdata_i: enable bit
//
// One beat at a time: accept, RAM read, execute, then the result goes to the output register.
// Ticks, target and read beats go straight from EXEC to OUT; setting writes first wait in DIV
// for the step division. The next beat is taken while a result still waits on m_axis.
// No clearing pass after reset: per-entry valid bits make untouched entries read as defaults.
module servo_ramp_multiplexer #(
  parameter int unsigned CHANNELS    = 8,
  parameter int unsigned MAX_ACTIVE  = 2,
  parameter int unsigned HOLD_PULSES = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // channel, data, select_mask, zero pad
  input  logic [2:0]  s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // pulse_valid, pulse_channel, pulse_width,
                                      // reached_bits, pending_bits, read_value
);

  localparam int unsigned PW    = $clog2(CHANNELS);
  localparam int unsigned ACT_W = $clog2(MAX_ACTIVE + 1);
  localparam int unsigned ENT_W = $bits(srm_pkg::srm_entry_t);
  localparam int unsigned DW    = srm_pkg::DIVIDEND_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e              state_q;
  srm_pkg::mode_e      mode_q;
  logic [2:0]          chan_q;
  logic [15:0]         data_q;
  logic [7:0]          mask_q;
  logic                enable_q;
  logic [PW-1:0]       ptr_q;
  logic [ACT_W-1:0]    act_q;
  logic [CHANNELS-1:0] reached_q;
  logic [CHANNELS-1:0] cmd_q;
  logic [CHANNELS-1:0] start_q;
  logic [CHANNELS-1:0] target_q;
  logic [CHANNELS-1:0] dir_q;
  logic [CHANNELS-1:0] valid_q;
  logic                rd_vld_q;
  srm_pkg::srm_entry_t ent_q;
  logic                pv_q;
  logic [2:0]          pch_q;
  logic [9:0]          pw_q;
  logic [9:0]          rv_q;
  logic                m_tvalid_q;
  logic [39:0]         m_tdata_q;

  logic                accept;
  srm_pkg::mode_e      in_mode;
  logic                ram_we;
  logic [PW-1:0]       ram_waddr;
  logic [ENT_W-1:0]    ram_wdata;
  logic [PW-1:0]       ram_raddr;
  logic [ENT_W-1:0]    ram_rdata;
  srm_pkg::srm_entry_t ent_rd;
  srm_pkg::srm_entry_t ent_set;
  srm_pkg::srm_entry_t ent_div;
  logic                chan_ok;
  logic                set_op;
  logic                tick_en;
  logic                div_start;
  logic                div_done;
  logic [DW-1:0]       dividend;
  logic [DW-1:0]       quot;
  logic [DW-1:0]       step_full;
  logic [9:0]          span;
  logic [9:0]          rd_val;
  logic [15:0]         mask_ext;
  logic [CHANNELS-1:0] tmask;
  logic [CHANNELS-1:0] chan_bit;
  logic [PW-1:0]       ptr_next;
  logic [ACT_W-1:0]    act_plus;
  logic [ACT_W-1:0]    act_next;
  logic                out_free;
  srm_pkg::srm_tick_in_t  tick_in;
  srm_pkg::srm_tick_out_t tick_out;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_mode       = srm_pkg::mode_e'(s_axis_tuser);
  assign out_free      = !m_tvalid_q || m_axis_tready;

  assign ram_raddr = (in_mode == srm_pkg::MODE_TICK) ? ptr_q : PW'(s_axis_tdata[2:0]);

  srm_ram #(
    .WIDTH(ENT_W),
    .DEPTH(CHANNELS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign ent_rd  = rd_vld_q ? srm_pkg::srm_entry_t'(ram_rdata) : srm_pkg::RESET_ENTRY;
  assign chan_ok = (32'(chan_q) < 32'(CHANNELS));
  assign set_op  = (mode_q == srm_pkg::MODE_WR_MIN) || (mode_q == srm_pkg::MODE_WR_MAX) ||
                   (mode_q == srm_pkg::MODE_WR_TIME);
  assign tick_en = (mode_q == srm_pkg::MODE_TICK) && enable_q;
  assign chan_bit = CHANNELS'(1) << ptr_q;

  // tick path
  always_comb begin
    tick_in           = '0;
    tick_in.ent       = ent_rd;
    tick_in.start_f   = start_q[ptr_q];
    tick_in.target_f  = target_q[ptr_q];
    tick_in.dir_f     = dir_q[ptr_q];
    tick_in.slot_free = (act_q < ACT_W'(MAX_ACTIVE));
  end

  srm_ramp #(
    .HOLD_PULSES(HOLD_PULSES)
  ) u_ramp (
    .tick_i(tick_in),
    .tick_o(tick_out)
  );

  assign ptr_next = (ptr_q == PW'(CHANNELS - 1)) ? '0 : ptr_q + 1'b1;
  assign act_plus = act_q + ACT_W'(tick_out.started);
  assign act_next = (tick_out.finished && (act_plus != '0)) ? act_plus - 1'b1 : act_plus;

  // target write mask, only the first eight channels are addressable
  assign mask_ext = 16'(mask_q);
  always_comb begin
    tmask = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      tmask[i] = (i < 8) ? mask_ext[i] : 1'b0;
    end
  end

  // setting writes with clamping
  always_comb begin
    ent_set = ent_rd;
    unique case (mode_q)
      srm_pkg::MODE_WR_MIN: begin
        ent_set.min_p = (data_q > 16'(ent_rd.max_p)) ? ent_rd.max_p : data_q[9:0];
        ent_set.min_w = srm_pkg::permille_to_width(ent_set.min_p);
      end
      srm_pkg::MODE_WR_MAX: begin
        if (data_q > 16'(srm_pkg::PERMILLE_MAX)) begin
          ent_set.max_p = srm_pkg::PERMILLE_MAX;
        end else if (data_q < 16'(ent_rd.min_p)) begin
          ent_set.max_p = ent_rd.min_p;
        end else begin
          ent_set.max_p = data_q[9:0];
        end
        ent_set.max_w = srm_pkg::permille_to_width(ent_set.max_p);
      end
      srm_pkg::MODE_WR_TIME: begin
        if (data_q > 16'(srm_pkg::TIME_MAX)) begin
          ent_set.move_time = srm_pkg::TIME_MAX;
        end else if (data_q < 16'(srm_pkg::TIME_MIN)) begin
          ent_set.move_time = srm_pkg::TIME_MIN;
        end else begin
          ent_set.move_time = data_q[9:0];
        end
      end
      default: ent_set = ent_rd;
    endcase
    span     = (ent_set.max_w >= ent_set.min_w) ? (ent_set.max_w - ent_set.min_w) : 10'd0;
    dividend = {span, 1'b0};
  end

  assign div_start = (state_q == ST_EXEC) && set_op && chan_ok;

  srm_div #(
    .DW(DW),
    .VW(10)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(dividend),
    .divisor_i (ent_set.move_time),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  assign step_full = (quot == '0) ? DW'(1) : quot;
  always_comb begin
    ent_div      = ent_q;
    ent_div.step = step_full[5:0] & srm_pkg::STEP_MASK;
  end

  always_comb begin
    unique case (mode_q)
      srm_pkg::MODE_RD_MIN:  rd_val = ent_rd.min_p;
      srm_pkg::MODE_RD_MAX:  rd_val = ent_rd.max_p;
      srm_pkg::MODE_RD_TIME: rd_val = ent_rd.move_time;
      default:               rd_val = 10'd0;
    endcase
    if (!chan_ok) begin
      rd_val = 10'd0;
    end
  end

  // RAM write-back: tick updates in EXEC, setting writes when the step is ready
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = ENT_W'(tick_out.ent);
    if (state_q == ST_EXEC && tick_en) begin
      ram_we = 1'b1;
    end else if (state_q == ST_DIV && div_done) begin
      ram_we    = 1'b1;
      ram_waddr = PW'(chan_q);
      ram_wdata = ENT_W'(ent_div);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      enable_q   <= 1'b0;
      ptr_q      <= '0;
      act_q      <= '0;
      reached_q  <= '0;
      cmd_q      <= '0;
      start_q    <= '1;
      target_q   <= '0;
      dir_q      <= '0;
      valid_q    <= '0;
      rd_vld_q   <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      if (state_q == ST_OUT && out_free) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tvalid_q && m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            rd_vld_q <= valid_q[ram_raddr];
            state_q  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          pv_q    <= tick_en && tick_out.pulse;
          pch_q   <= 3'(ptr_q);
          pw_q    <= tick_en ? tick_out.width : 10'd0;
          rv_q    <= rd_val;
          state_q <= (set_op && chan_ok) ? ST_DIV : ST_OUT;
          if (tick_en) begin
            act_q <= act_next;
            ptr_q <= ptr_next;
            dir_q[ptr_q] <= tick_out.dir;
            if (tick_out.started) begin
              start_q[ptr_q] <= 1'b0;
            end
            if (tick_out.reach_set) begin
              reached_q <= reached_q | chan_bit;
            end else if (tick_out.reach_clr) begin
              reached_q <= reached_q & ~chan_bit;
            end
          end
          if (mode_q == srm_pkg::MODE_TARGETS) begin
            cmd_q    <= (cmd_q & ~tmask) | (CHANNELS'(data_q) & tmask);
            start_q  <= start_q | tmask;
            target_q <= (target_q & ~tmask) | (CHANNELS'(data_q) & tmask);
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= in_mode;
      chan_q <= s_axis_tdata[2:0];
      data_q <= s_axis_tdata[18:3];
      mask_q <= s_axis_tdata[26:19];
    end
    if (div_start) begin
      ent_q <= ent_set;
    end
    if (state_q == ST_OUT && out_free) begin
      m_tdata_q <= {rv_q, 8'(cmd_q ^ reached_q), 8'(reached_q), pw_q, pch_q, pv_q};
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

endmodule
